// ----- hdl/latc_pkg.sv -----
// Shared types and constants for the logic analyzer trigger/capture block.
// No dependencies; used by latc_front, latc_back and the top level.
package latc_pkg;

    localparam int CNT_W          = 13;
    localparam int BYTE_W         = 8;
    localparam int CFG_IDX_W      = 2;
    localparam int QUEUE_DEPTH    = 2;
    localparam logic [CNT_W-1:0] READBACK_RESET = 13'd100;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_ARMED = 2'd1,
        PH_POST  = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_ARM    = 2'd1,
        OP_READ   = 2'd2
    } opcode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TRIG_MASK  = 2'd0,
        CFG_TRIG_VALUE = 2'd1,
        CFG_POST_COUNT = 2'd2,
        CFG_READBACK   = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [BYTE_W-1:0] sample_value;
    } in_word_t;

    typedef struct packed {
        logic [BYTE_W-1:0] read_data;
        logic              data_valid;
        logic              last_read;
        logic [1:0]        phase;
    } out_word_t;

    typedef struct packed {
        logic              wr_en;
        logic              rd_en;
        logic [BYTE_W-1:0] wr_data;
        logic              last;
        phase_t            phase;
    } cmd_t;

endpackage

// ----- hdl/latc_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module latc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/latc_queue.sv -----
// Short FIFO between the front and back parts of the capture engine.
// No dependencies.
module latc_queue #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty,
    output logic             full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data = slot_reg[rd_ptr_reg];
    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CW'(DEPTH));

    assert property (@(posedge clk) disable iff (!rst_n) push |-> (!full || pop))
        else $error("queue overflow");
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
        else $error("queue underflow");

endmodule

// ----- hdl/latc_front.sv -----
// Front part: configuration registers, capture phase, write index and counters.
// Turns each accepted word into a store command. Depends on latc_pkg.
module latc_front #(
    parameter int STORE_DEPTH = 8192
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [latc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [latc_pkg::CNT_W-1:0]     cfg_data,
    input  logic                           accept,
    input  latc_pkg::in_word_t             in_data,
    output latc_pkg::cmd_t                 cmd,
    output logic [$clog2(STORE_DEPTH)-1:0] cmd_addr
);

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int BW = latc_pkg::BYTE_W;
    localparam int CW = latc_pkg::CNT_W;

    logic [BW-1:0]       trig_mask_reg, trig_mask_next;
    logic [BW-1:0]       trig_value_reg, trig_value_next;
    logic [CW-1:0]       post_count_reg, post_count_next;
    logic [CW-1:0]       readback_reg, readback_next;
    latc_pkg::phase_t    phase_reg, phase_next;
    logic [AW-1:0]       index_reg, index_next;
    logic [CW-1:0]       delay_reg, delay_next;
    logic [CW-1:0]       reads_reg, reads_next;
    logic [AW-1:0]       index_inc, index_dec;
    logic [CW-1:0]       delay_dec;
    logic                trig_hit;

    assign index_inc = (index_reg == AW'(STORE_DEPTH - 1)) ? '0 : index_reg + 1'b1;
    assign index_dec = (index_reg == '0) ? AW'(STORE_DEPTH - 1) : index_reg - 1'b1;
    assign delay_dec = (delay_reg != '0) ? delay_reg - 1'b1 : '0;
    assign trig_hit  = (((in_data.sample_value ^ trig_value_reg) & trig_mask_reg) == '0);

    always_comb
    begin
        trig_mask_next  = trig_mask_reg;
        trig_value_next = trig_value_reg;
        post_count_next = post_count_reg;
        readback_next   = readback_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                latc_pkg::CFG_TRIG_MASK:  trig_mask_next  = cfg_data[BW-1:0];
                latc_pkg::CFG_TRIG_VALUE: trig_value_next = cfg_data[BW-1:0];
                latc_pkg::CFG_POST_COUNT: post_count_next = cfg_data;
                latc_pkg::CFG_READBACK:   readback_next   = cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        phase_next    = phase_reg;
        index_next    = index_reg;
        delay_next    = delay_reg;
        reads_next    = reads_reg;
        cmd.wr_en     = 1'b0;
        cmd.rd_en     = 1'b0;
        cmd.wr_data   = in_data.sample_value;
        cmd.last      = 1'b0;
        cmd_addr      = index_reg;
        if (accept)
        begin
            case (in_data.opcode)
                latc_pkg::OP_SAMPLE:
                begin
                    if (phase_reg == latc_pkg::PH_ARMED)
                    begin
                        cmd.wr_en = 1'b1;
                        if (trig_hit)
                        begin
                            delay_next = post_count_reg;
                            phase_next = (post_count_reg == '0) ? latc_pkg::PH_IDLE
                                                                : latc_pkg::PH_POST;
                        end
                        else
                        begin
                            index_next = index_inc;
                        end
                    end
                    else if (phase_reg == latc_pkg::PH_POST)
                    begin
                        cmd.wr_en  = 1'b1;
                        index_next = index_inc;
                        delay_next = delay_dec;
                        if (delay_dec == '0)
                        begin
                            phase_next = latc_pkg::PH_IDLE;
                        end
                    end
                end
                latc_pkg::OP_ARM:
                begin
                    index_next = '0;
                    reads_next = readback_reg;
                    delay_next = '0;
                    phase_next = latc_pkg::PH_ARMED;
                end
                latc_pkg::OP_READ:
                begin
                    if (phase_reg == latc_pkg::PH_IDLE && reads_reg != '0)
                    begin
                        index_next = index_dec;
                        cmd_addr   = index_dec;
                        cmd.rd_en  = 1'b1;
                        reads_next = reads_reg - 1'b1;
                        cmd.last   = (reads_reg == CW'(1));
                    end
                end
                default: ;
            endcase
        end
        cmd.phase = phase_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trig_mask_reg  <= '0;
            trig_value_reg <= '0;
            post_count_reg <= '0;
            readback_reg   <= latc_pkg::READBACK_RESET;
            phase_reg      <= latc_pkg::PH_IDLE;
            index_reg      <= '0;
            delay_reg      <= '0;
            reads_reg      <= '0;
        end
        else
        begin
            trig_mask_reg  <= trig_mask_next;
            trig_value_reg <= trig_value_next;
            post_count_reg <= post_count_next;
            readback_reg   <= readback_next;
            phase_reg      <= phase_next;
            index_reg      <= index_next;
            delay_reg      <= delay_next;
            reads_reg      <= reads_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd.rd_en) |-> (phase_reg == latc_pkg::PH_IDLE && reads_reg != '0))
        else $error("read issued outside idle phase or with empty readback");
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == latc_pkg::PH_POST) |-> (delay_reg != '0))
        else $error("post-trigger phase with exhausted delay");

endmodule

// ----- hdl/latc_back.sv -----
// Back part: clears the capture store after reset, then runs store commands
// from the queue and holds the result word. Depends on latc_pkg, latc_ram.
module latc_back #(
    parameter int STORE_DEPTH = 8192
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           q_empty,
    input  latc_pkg::cmd_t                 q_cmd,
    input  logic [$clog2(STORE_DEPTH)-1:0] q_addr,
    output logic                           q_pop,
    output logic                           clear_busy,
    output logic                           out_valid,
    input  logic                           out_stall,
    output latc_pkg::out_word_t            out_data
);

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int BW = latc_pkg::BYTE_W;

    logic             clearing_reg, clearing_next;
    logic [AW-1:0]    clr_addr_reg, clr_addr_next;
    logic             out_valid_reg, out_valid_next;
    latc_pkg::cmd_t   meta_reg;
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [BW-1:0]    ram_wdata;
    logic [BW-1:0]    ram_rdata;

    assign q_pop = !q_empty && !clearing_reg && (!out_valid_reg || !out_stall);

    assign ram_we    = clearing_reg || (q_pop && q_cmd.wr_en);
    assign ram_waddr = clearing_reg ? clr_addr_reg : q_addr;
    assign ram_wdata = clearing_reg ? '0 : q_cmd.wr_data;

    latc_ram #(
        .WIDTH (BW),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (q_pop && q_cmd.rd_en),
        .raddr (q_addr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        clearing_next  = clearing_reg;
        clr_addr_next  = clr_addr_reg;
        out_valid_next = out_valid_reg;
        if (clearing_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == AW'(STORE_DEPTH - 1))
            begin
                clearing_next = 1'b0;
                clr_addr_next = '0;
            end
        end
        if (q_pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clearing_reg  <= clearing_next;
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            meta_reg <= q_cmd;
        end
    end

    assign clear_busy          = clearing_reg;
    assign out_valid           = out_valid_reg;
    assign out_data.read_data  = meta_reg.rd_en ? ram_rdata : '0;
    assign out_data.data_valid = meta_reg.rd_en;
    assign out_data.last_read  = meta_reg.last;
    assign out_data.phase      = meta_reg.phase;

    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> !clearing_reg)
        else $error("command popped during store clear");
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(q_pop))
        else $error("result appeared without a command");
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(clearing_reg) |-> ($past(clr_addr_reg) == AW'(STORE_DEPTH - 1)))
        else $error("store clear ended early");

endmodule

// ----- hdl/logic_analyzer_trigger_capture_top.sv -----
// Top level of the logic analyzer trigger/capture engine.
// Depends on latc_pkg, latc_front, latc_queue, latc_back, latc_ram.
//
// Channels: in_data words (opcode, sample_value) on in_valid/in_stall,
// one out_data word per input word on out_valid/out_stall, and a register
// write port (cfg_valid/cfg_ready, cfg_index, cfg_data) that is always ready.
// Opcodes: sample tick, arm, read next stored byte. A read returns bytes
// walking backwards from the write index, flagging the last of the run.
// Throughput: one word per cycle while in_stall is low. With the queue empty,
// an accepted word is pushed into the queue, then popped with the store read,
// and the result word is registered and presented with out_valid.
// Reset: control state and registers clear at once; readback count is 100.
// The store is then cleared one entry per cycle with in_stall high;
// register writes are taken during the clear.
// Stall: when out_stall holds, the result word holds and up to two more
// words queue behind it before in_stall rises.
module logic_analyzer_trigger_capture_top #(
    parameter int STORE_DEPTH = 8192
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  latc_pkg::in_word_t             in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output latc_pkg::out_word_t            out_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [latc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [latc_pkg::CNT_W-1:0]     cfg_data
);

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int QW = $bits(latc_pkg::cmd_t) + AW;

    logic                accept;
    latc_pkg::cmd_t      f_cmd;
    logic [AW-1:0]       f_addr;
    logic [QW-1:0]       q_head;
    logic                q_pop, q_empty, q_full;
    logic                clear_busy;
    latc_pkg::cmd_t      b_cmd;
    logic [AW-1:0]       b_addr;

    assign cfg_ready = 1'b1;
    assign in_stall  = q_full || clear_busy;
    assign accept    = in_valid && !in_stall;

    latc_front #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .in_data   (in_data),
        .cmd       (f_cmd),
        .cmd_addr  (f_addr)
    );

    latc_queue #(
        .WIDTH (QW),
        .DEPTH (latc_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data ({f_cmd, f_addr}),
        .pop       (q_pop),
        .pop_data  (q_head),
        .empty     (q_empty),
        .full      (q_full)
    );

    assign b_cmd  = q_head[QW-1:AW];
    assign b_addr = q_head[AW-1:0];

    latc_back #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_cmd      (b_cmd),
        .q_addr     (b_addr),
        .q_pop      (q_pop),
        .clear_busy (clear_busy),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

endmodule
